[rtl/core/spr_pkg.sv]
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the servo bus packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned MaxFrameW = 9;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [TimeoutW-1:0]  TimeoutReset  = 16'd10;
  localparam logic [MaxFrameW-1:0] MaxFrameReset = 9'd64;

  localparam logic [7:0] HeaderByte = 8'hFF;

  typedef enum logic {
    CfgTimeout  = 1'b0,
    CfgMaxFrame = 1'b1
  } cfg_index_e;

  typedef enum logic {
    CmdByte = 1'b0,
    CmdTick = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    KindParam    = 2'd0,
    KindDone     = 2'd1,
    KindTimeout  = 2'd2,
    KindOverflow = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PhHunt1 = 3'd0,
    PhHunt2 = 3'd1,
    PhId    = 3'd2,
    PhLen   = 3'd3,
    PhInstr = 3'd4,
    PhParam = 3'd5,
    PhCheck = 3'd6
  } phase_e;

  typedef struct packed {
    logic                 valid;
    kind_e                kind;
    logic [7:0]           servo_id;
    logic [7:0]           instruction;
    logic [7:0]           param_index;
    logic [7:0]           param_byte;
    logic [7:0]           param_count;
    logic                 checksum_ok;
    logic [MaxFrameW-1:0] frame_bytes;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/spr_parser.sv]
// ----------------------------------------------------------------------------
// spr_parser
// Frame state, checksum and timers; produces at most one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          item_valid_i,
  input  wire logic                          command_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic [spr_pkg::TimeoutW-1:0]  timeout_ticks_i,
  input  wire logic [spr_pkg::MaxFrameW-1:0] max_frame_bytes_i,
  output spr_pkg::result_t                   res_o
);

  spr_pkg::phase_e                 phase_q, phase_d;
  logic [spr_pkg::MaxFrameW-1:0]   byte_count_q, byte_count_d;
  logic [7:0]                      frame_length_q, frame_length_d;
  logic [7:0]                      frame_id_q, frame_id_d;
  logic [7:0]                      frame_instr_q, frame_instr_d;
  logic [7:0]                      running_sum_q, running_sum_d;
  logic [spr_pkg::TimeoutW-1:0]    idle_ticks_q, idle_ticks_d;

  logic [spr_pkg::TimeoutW-1:0]    idle_inc;
  logic [spr_pkg::MaxFrameW-1:0]   count_inc;
  logic [9:0]                      last_pos;
  logic                            last_param;
  logic [7:0]                      param_count;
  logic                            go_hunt;

  assign idle_inc    = idle_ticks_q + 16'd1;
  assign count_inc   = byte_count_q + 9'd1;
  assign last_pos    = {2'b00, frame_length_q} + 10'd3;
  assign last_param  = {1'b0, count_inc} >= last_pos;
  assign param_count = (frame_length_q >= 8'd2) ? frame_length_q - 8'd2 : 8'd0;

  always_comb begin
    phase_d        = phase_q;
    byte_count_d   = byte_count_q;
    frame_length_d = frame_length_q;
    frame_id_d     = frame_id_q;
    frame_instr_d  = frame_instr_q;
    running_sum_d  = running_sum_q;
    idle_ticks_d   = idle_ticks_q;
    go_hunt        = 1'b0;
    res_o          = '0;
    res_o.kind     = spr_pkg::KindParam;

    if (item_valid_i) begin
      if (command_i == spr_pkg::CmdTick) begin
        if (idle_inc >= timeout_ticks_i || idle_inc == '0) begin
          idle_ticks_d = '0;
          go_hunt      = 1'b1;
          res_o.valid  = 1'b1;
          res_o.kind   = spr_pkg::KindTimeout;
        end else begin
          idle_ticks_d = idle_inc;
        end
      end else begin
        idle_ticks_d = '0;
        byte_count_d = count_inc;
        if (count_inc > max_frame_bytes_i) begin
          go_hunt     = 1'b1;
          res_o.valid = 1'b1;
          res_o.kind  = spr_pkg::KindOverflow;
        end else begin
          case (phase_q)
            spr_pkg::PhHunt2: begin
              if (data_byte_i == spr_pkg::HeaderByte) begin
                phase_d = spr_pkg::PhId;
              end else begin
                go_hunt = 1'b1;
              end
            end
            spr_pkg::PhId: begin
              frame_id_d    = data_byte_i;
              running_sum_d = data_byte_i;
              phase_d       = spr_pkg::PhLen;
            end
            spr_pkg::PhLen: begin
              frame_length_d = data_byte_i;
              running_sum_d  = running_sum_q + data_byte_i;
              phase_d        = spr_pkg::PhInstr;
            end
            spr_pkg::PhInstr: begin
              frame_instr_d = data_byte_i;
              running_sum_d = running_sum_q + data_byte_i;
              phase_d       = last_param ? spr_pkg::PhCheck : spr_pkg::PhParam;
            end
            spr_pkg::PhParam: begin
              running_sum_d     = running_sum_q + data_byte_i;
              if (last_param) begin
                phase_d = spr_pkg::PhCheck;
              end
              res_o.valid       = 1'b1;
              res_o.kind        = spr_pkg::KindParam;
              res_o.servo_id    = frame_id_q;
              res_o.instruction = frame_instr_q;
              res_o.param_index = count_inc[7:0] - 8'd6;
              res_o.param_byte  = data_byte_i;
              res_o.param_count = param_count;
            end
            spr_pkg::PhCheck: begin
              go_hunt           = 1'b1;
              res_o.valid       = 1'b1;
              res_o.kind        = spr_pkg::KindDone;
              res_o.servo_id    = frame_id_q;
              res_o.instruction = frame_instr_q;
              res_o.param_count = param_count;
              res_o.checksum_ok = (~running_sum_q == data_byte_i);
              res_o.frame_bytes = count_inc;
            end
            default: begin
              if (data_byte_i == spr_pkg::HeaderByte) begin
                phase_d = spr_pkg::PhHunt2;
              end else begin
                go_hunt = 1'b1;
              end
            end
          endcase
        end
      end
    end

    if (go_hunt) begin
      phase_d        = spr_pkg::PhHunt1;
      byte_count_d   = '0;
      frame_length_d = '0;
      frame_id_d     = '0;
      frame_instr_d  = '0;
      running_sum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= spr_pkg::PhHunt1;
      byte_count_q   <= '0;
      frame_length_q <= '0;
      frame_id_q     <= '0;
      frame_instr_q  <= '0;
      running_sum_q  <= '0;
      idle_ticks_q   <= '0;
    end else begin
      phase_q        <= phase_d;
      byte_count_q   <= byte_count_d;
      frame_length_q <= frame_length_d;
      frame_id_q     <= frame_id_d;
      frame_instr_q  <= frame_instr_d;
      running_sum_q  <= running_sum_d;
      idle_ticks_q   <= idle_ticks_d;
    end
  end

  a_error_rehunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.kind == spr_pkg::KindTimeout ||
                    res_o.kind == spr_pkg::KindOverflow)
    |=> phase_q == spr_pkg::PhHunt1 && byte_count_q == '0)
    else $error("error result did not return the parser to hunting");

  a_byte_clears_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && command_i == spr_pkg::CmdByte |=> idle_ticks_q == '0)
    else $error("received byte did not clear the idle tick count");

  a_param_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == spr_pkg::KindParam |-> phase_q == spr_pkg::PhParam)
    else $error("parameter result outside the parameter phase");

  a_done_rehunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == spr_pkg::KindDone
    |=> phase_q == spr_pkg::PhHunt1 && running_sum_q == '0)
    else $error("completed frame did not return the parser to hunting");

endmodule

`default_nettype wire

[rtl/core/servo_packet_receiver_unit.sv]
// ----------------------------------------------------------------------------
// servo_packet_receiver_unit
// Parses half-duplex servo bus frames from a stream of bytes and time ticks.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in        sink       in_valid/in_ready     command, data_byte
//  out       source     out_valid/out_ready   kind, servo_id, instruction,
//                                             param_index, param_byte,
//                                             param_count, checksum_ok,
//                                             frame_bytes
//  cfg       sink       cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One transaction is taken per cycle unless a stalled output blocks input.
// The input register and the result register each hold one transaction, and
// the parser state is updated in a single pass between them.
// A stalled output holds the input register, which then blocks new input.
// Reset returns to hunting with the default timeout and frame size limit.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_packet_receiver_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       servo_id_o,
  output logic [7:0]       instruction_o,
  output logic [7:0]       param_index_o,
  output logic [7:0]       param_byte_o,
  output logic [7:0]       param_count_o,
  output logic             checksum_ok_o,
  output logic [8:0]       frame_bytes_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic                            in_valid_q;
  logic                            command_q;
  logic [7:0]                      data_byte_q;
  logic                            proc_fire;
  logic [spr_pkg::TimeoutW-1:0]    timeout_ticks_q;
  logic [spr_pkg::MaxFrameW-1:0]   max_frame_bytes_q;
  spr_pkg::result_t                res;
  spr_pkg::result_t                out_q;

  assign proc_fire   = in_valid_q && (!out_q.valid || out_ready_i);
  assign in_ready_o  = !in_valid_q || proc_fire;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q   <= spr_pkg::TimeoutReset;
      max_frame_bytes_q <= spr_pkg::MaxFrameReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spr_pkg::CfgTimeout: begin
          timeout_ticks_q <= cfg_data_i;
        end
        spr_pkg::CfgMaxFrame: begin
          max_frame_bytes_q <= cfg_data_i[spr_pkg::MaxFrameW-1:0];
        end
        default: begin
          timeout_ticks_q <= timeout_ticks_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      command_q   <= command_i;
      data_byte_q <= data_byte_i;
    end
  end

  spr_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (proc_fire),
    .command_i         (command_q),
    .data_byte_i       (data_byte_q),
    .timeout_ticks_i   (timeout_ticks_q),
    .max_frame_bytes_i (max_frame_bytes_q),
    .res_o             (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (proc_fire) begin
      out_q <= res;
    end else if (out_ready_i) begin
      out_q.valid <= 1'b0;
    end
  end

  assign out_valid_o   = out_q.valid;
  assign kind_o        = out_q.kind;
  assign servo_id_o    = out_q.servo_id;
  assign instruction_o = out_q.instruction;
  assign param_index_o = out_q.param_index;
  assign param_byte_o  = out_q.param_byte;
  assign param_count_o = out_q.param_count;
  assign checksum_ok_o = out_q.checksum_ok;
  assign frame_bytes_o = out_q.frame_bytes;

  a_stalled_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_q.valid && !out_ready_i
    |=> in_valid_q && $stable(data_byte_q) && $stable(command_q))
    else $error("pending transaction lost while the output was stalled");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && res.valid |=> out_q.valid)
    else $error("parser result was not captured in the result register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q.valid && !out_ready_i |-> !proc_fire)
    else $error("parser advanced while the result register was full");

endmodule

`default_nettype wire

[sim/servo_packet_receiver_unit_test.sv]
// ----------------------------------------------------------------------------
// servo_packet_receiver_unit_test
// Self-checking testbench of the servo bus packet receiver. A frame predictor
// follows every accepted byte and tick and keeps the results due from the
// block; each result transaction is checked against the oldest one of them.
// Directed frames come first, then random frames, noise and ticks under
// changing limits, and last the largest frame at the limit and a small frame
// just past it.
// ----------------------------------------------------------------------------
module servo_packet_receiver_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomItems = 120;
  localparam int unsigned SettleWait  = 8;
  localparam int unsigned WholeFrame  = 300;

  class servo_frame_checker;
    spr_pkg::phase_e    phase;
    logic [8:0]         byte_count;
    logic [7:0]         frame_length;
    logic [7:0]         frame_id;
    logic [7:0]         frame_instr;
    logic [7:0]         running_sum;
    logic [15:0]        idle_ticks;
    logic [15:0]        timeout_ticks;
    logic [8:0]         max_frame;
    spr_pkg::result_t   expected_results[$];
    int unsigned        failures;

    function new();
      timeout_ticks = spr_pkg::TimeoutReset;
      max_frame     = spr_pkg::MaxFrameReset;
      idle_ticks    = '0;
      failures      = 0;
      restart_hunt();
    endfunction

    function void restart_hunt();
      phase        = spr_pkg::PhHunt1;
      byte_count   = '0;
      frame_length = '0;
      frame_id     = '0;
      frame_instr  = '0;
      running_sum  = '0;
    endfunction

    function void write_register(spr_pkg::cfg_index_e idx, logic [15:0] data);
      if (idx == spr_pkg::CfgTimeout) begin
        timeout_ticks = data;
      end else begin
        max_frame = data[spr_pkg::MaxFrameW-1:0];
      end
    endfunction

    function bit params_done();
      return int'(byte_count) >= int'(frame_length) + 3;
    endfunction

    function void push_result(spr_pkg::kind_e k, logic [7:0] pidx, logic [7:0] pbyte,
                              logic ok, logic [8:0] total, bit with_frame);
      spr_pkg::result_t r;
      r = '0;
      r.valid       = 1'b1;
      r.kind        = k;
      r.param_index = pidx;
      r.param_byte  = pbyte;
      r.checksum_ok = ok;
      r.frame_bytes = total;
      if (with_frame) begin
        r.servo_id    = frame_id;
        r.instruction = frame_instr;
        r.param_count = (frame_length >= 8'd2) ? frame_length - 8'd2 : 8'd0;
      end
      expected_results.push_back(r);
    endfunction

    function void accept_item(spr_pkg::command_e cmd, logic [7:0] b);
      logic [7:0] pidx;
      if (cmd == spr_pkg::CmdTick) begin
        idle_ticks = idle_ticks + 16'd1;
        if (idle_ticks >= timeout_ticks || idle_ticks == 16'd0) begin
          idle_ticks = '0;
          restart_hunt();
          push_result(spr_pkg::KindTimeout, '0, '0, 1'b0, '0, 1'b0);
        end
        return;
      end
      idle_ticks = '0;
      byte_count = byte_count + 9'd1;
      if (byte_count > max_frame) begin
        restart_hunt();
        push_result(spr_pkg::KindOverflow, '0, '0, 1'b0, '0, 1'b0);
        return;
      end
      case (phase)
        spr_pkg::PhHunt2: begin
          if (b == spr_pkg::HeaderByte) phase = spr_pkg::PhId;
          else restart_hunt();
        end
        spr_pkg::PhId: begin
          frame_id    = b;
          running_sum = b;
          phase       = spr_pkg::PhLen;
        end
        spr_pkg::PhLen: begin
          frame_length = b;
          running_sum  = running_sum + b;
          phase        = spr_pkg::PhInstr;
        end
        spr_pkg::PhInstr: begin
          frame_instr = b;
          running_sum = running_sum + b;
          phase       = params_done() ? spr_pkg::PhCheck : spr_pkg::PhParam;
        end
        spr_pkg::PhParam: begin
          pidx        = 8'(byte_count - 9'd6);
          running_sum = running_sum + b;
          if (params_done()) phase = spr_pkg::PhCheck;
          push_result(spr_pkg::KindParam, pidx, b, 1'b0, '0, 1'b1);
        end
        spr_pkg::PhCheck: begin
          push_result(spr_pkg::KindDone, '0, '0, (~running_sum == b), byte_count, 1'b1);
          restart_hunt();
        end
        default: begin
          if (b == spr_pkg::HeaderByte) phase = spr_pkg::PhHunt2;
          else restart_hunt();
        end
      endcase
    endfunction

    function void check_result(spr_pkg::result_t got);
      spr_pkg::result_t want;
      if (expected_results.size() == 0) begin
        if (failures < 10) begin
          $display("ERROR: unexpected result kind %0d id %02h instr %02h", got.kind,
                   got.servo_id, got.instruction);
        end
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        if (failures < 10) begin
          $display({"ERROR: expected kind %0d id %02h instr %02h idx %0d byte %02h",
                    " cnt %0d ok %0b len %0d"},
                   want.kind, want.servo_id, want.instruction, want.param_index,
                   want.param_byte, want.param_count, want.checksum_ok, want.frame_bytes);
          $display({"       got      kind %0d id %02h instr %02h idx %0d byte %02h",
                    " cnt %0d ok %0b len %0d"},
                   got.kind, got.servo_id, got.instruction, got.param_index,
                   got.param_byte, got.param_count, got.checksum_ok, got.frame_bytes);
        end
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  servo_id_o;
  logic [7:0]  instruction_o;
  logic [7:0]  param_index_o;
  logic [7:0]  param_byte_o;
  logic [7:0]  param_count_o;
  logic        checksum_ok_o;
  logic [8:0]  frame_bytes_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  servo_frame_checker chk;
  int unsigned        cycles = 0;
  int unsigned        item_count = 0;
  int unsigned        ready_hold = 0;
  bit                 no_idle = 1'b0;

  servo_packet_receiver_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .servo_id_o    (servo_id_o),
    .instruction_o (instruction_o),
    .param_index_o (param_index_o),
    .param_byte_o  (param_byte_o),
    .param_count_o (param_count_o),
    .checksum_ok_o (checksum_ok_o),
    .frame_bytes_o (frame_bytes_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold  <= ready_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    spr_pkg::result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got             = '0;
      got.valid       = 1'b1;
      got.kind        = spr_pkg::kind_e'(kind_o);
      got.servo_id    = servo_id_o;
      got.instruction = instruction_o;
      got.param_index = param_index_o;
      got.param_byte  = param_byte_o;
      got.param_count = param_count_o;
      got.checksum_ok = checksum_ok_o;
      got.frame_bytes = frame_bytes_o;
      chk.check_result(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input spr_pkg::command_e cmd, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    chk.accept_item(cmd, b);
    item_count++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input logic [7:0] instr, input bit good_sum,
                            input int unsigned keep, input bit with_ticks);
    logic [7:0]  bytes_q[$];
    logic [7:0]  sum;
    logic [7:0]  p;
    int unsigned nparams;
    bytes_q = {spr_pkg::HeaderByte, spr_pkg::HeaderByte, id, len, instr};
    sum     = id + len + instr;
    nparams = (len >= 8'd2) ? len - 8'd2 : 0;
    for (int unsigned i = 0; i < nparams; i++) begin
      p = 8'($urandom_range(0, 255));
      bytes_q.push_back(p);
      sum = sum + p;
    end
    bytes_q.push_back(good_sum ? ~sum : ~sum ^ 8'($urandom_range(1, 255)));
    for (int unsigned i = 0; i < bytes_q.size() && i < keep; i++) begin
      if (with_ticks && i > 0 && $urandom_range(0, 15) == 0) begin
        send_item(spr_pkg::CmdTick, 8'($urandom_range(0, 255)));
      end
      send_item(spr_pkg::CmdByte, bytes_q[i]);
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (chk.pending() != 0) @(negedge clk_i);
    repeat (SettleWait) @(negedge clk_i);
  endtask

  task automatic write_register(input spr_pkg::cfg_index_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    chk.write_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_sequence();
    int unsigned r;
    int unsigned s;
    int          cap;
    int          len;
    r   = $urandom_range(0, 99);
    cap = int'(chk.max_frame) - 4;
    if (cap > 255) cap = 255;
    if (r < 65) begin
      s   = $urandom_range(0, 9);
      len = $urandom_range(0, (cap < 12) ? cap : 12);
      if (s >= 6 && s < 8 && cap <= 40) len = cap;
      else if (s == 8 && cap <= 40) len = cap + 1;
      else if (s == 9) len = $urandom_range(0, (cap < 20) ? cap : 20);
      send_frame(8'($urandom_range(0, 255)), 8'(len), 8'($urandom_range(0, 255)),
                 $urandom_range(0, 4) != 0, WholeFrame, 1'b1);
    end else if (r < 75) begin
      repeat ($urandom_range(1, 12)) send_item(spr_pkg::CmdTick, 8'($urandom_range(0, 255)));
    end else if (r < 85) begin
      repeat ($urandom_range(1, 4)) begin
        send_item(spr_pkg::CmdByte,
                  $urandom_range(0, 1) ? spr_pkg::HeaderByte : 8'($urandom_range(0, 255)));
      end
    end else begin
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 12)),
                 8'($urandom_range(0, 255)), 1'b1, $urandom_range(1, 8), 1'b0);
      repeat ($urandom_range(0, 12)) send_item(spr_pkg::CmdTick, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned burst_end;
    int unsigned random_start;
    chk = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_frame(8'h01, 8'd4, 8'h03, 1'b1, WholeFrame, 1'b0);
    send_frame(spr_pkg::HeaderByte, 8'd0, 8'hAA, 1'b0, WholeFrame, 1'b0);
    send_item(spr_pkg::CmdByte, spr_pkg::HeaderByte);
    send_item(spr_pkg::CmdByte, 8'h00);
    wait_drain();
    write_register(spr_pkg::CfgTimeout, 16'd2);
    write_register(spr_pkg::CfgMaxFrame, 16'd6);
    send_item(spr_pkg::CmdTick, 8'h00);
    send_item(spr_pkg::CmdTick, 8'hFF);
    send_frame(8'h7E, 8'd1, 8'h00, 1'b1, WholeFrame, 1'b0);
    send_frame(8'h10, 8'd3, 8'h02, 1'b1, WholeFrame, 1'b0);

    random_start = item_count;
    while (item_count - random_start < RandomItems) begin
      wait_drain();
      case ($urandom_range(0, 3))
        0: write_register(spr_pkg::CfgTimeout, 16'($urandom_range(0, 3) == 0 ? 1 :
                          $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(2, 12)));
        1: write_register(spr_pkg::CfgMaxFrame, 16'($urandom_range(0, 3) == 0 ? 6 :
                          $urandom_range(0, 3) == 0 ? 259 : $urandom_range(7, 40)));
        2: begin
          write_register(spr_pkg::CfgTimeout,
                         16'($urandom_range(0, 1) ? 1 : $urandom_range(2, 12)));
          write_register(spr_pkg::CfgMaxFrame,
                         16'($urandom_range(0, 1) ? 6 : $urandom_range(7, 40)));
        end
        default: ;
      endcase
      no_idle   = ($urandom_range(0, 4) == 0);
      burst_end = item_count + $urandom_range(30, 70);
      while (item_count < burst_end) random_sequence();
    end

    wait_drain();
    no_idle = 1'b0;
    write_register(spr_pkg::CfgMaxFrame, 16'd259);
    write_register(spr_pkg::CfgTimeout, 16'd65535);
    send_frame(8'hFE, 8'd255, 8'hFF, 1'b1, WholeFrame, 1'b1);
    wait_drain();
    write_register(spr_pkg::CfgMaxFrame, 16'd20);
    send_frame(8'h00, 8'd17, 8'h01, 1'b1, WholeFrame, 1'b0);
    wait_drain();

    if (chk.failures == 0 && chk.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/spr_pkg.sv
rtl/core/spr_parser.sv
rtl/core/servo_packet_receiver_unit.sv
sim/servo_packet_receiver_unit_test.sv
